// ===== rtl/c8eu_pkg.sv =====
// ----------------------------------------------------------------------------
// c8eu_pkg
// Shared types and constants of the 8-bit execute unit.
// ----------------------------------------------------------------------------
package c8eu_pkg;

    typedef enum logic [5:0] {
        OP_ADC = 6'd0,  OP_SBC = 6'd1,  OP_AND = 6'd2,  OP_ORA = 6'd3,
        OP_EOR = 6'd4,  OP_ASL = 6'd5,  OP_LSR = 6'd6,  OP_ROL = 6'd7,
        OP_ROR = 6'd8,  OP_BIT = 6'd9,  OP_CMP = 6'd10, OP_CPX = 6'd11,
        OP_CPY = 6'd12, OP_INC = 6'd13, OP_DEC = 6'd14, OP_INX = 6'd15,
        OP_INY = 6'd16, OP_DEX = 6'd17, OP_DEY = 6'd18, OP_LDA = 6'd19,
        OP_LDX = 6'd20, OP_LDY = 6'd21, OP_STA = 6'd22, OP_STX = 6'd23,
        OP_STY = 6'd24, OP_TAX = 6'd25, OP_TAY = 6'd26, OP_TXA = 6'd27,
        OP_TYA = 6'd28, OP_TSX = 6'd29, OP_TXS = 6'd30, OP_CLC = 6'd31,
        OP_SEC = 6'd32, OP_CLI = 6'd33, OP_SEI = 6'd34, OP_CLD = 6'd35,
        OP_SED = 6'd36, OP_CLV = 6'd37, OP_BCC = 6'd38, OP_BCS = 6'd39,
        OP_BEQ = 6'd40, OP_BNE = 6'd41, OP_BMI = 6'd42, OP_BPL = 6'd43,
        OP_BVC = 6'd44, OP_BVS = 6'd45, OP_NOP = 6'd46
    } op_t;

    localparam int FLAG_C = 0;
    localparam int FLAG_Z = 1;
    localparam int FLAG_I = 2;
    localparam int FLAG_D = 3;
    localparam int FLAG_U = 5;
    localparam int FLAG_V = 6;
    localparam int FLAG_N = 7;

    localparam logic [7:0] SP_RESET = 8'hFD;

    // classified item
    typedef struct packed {
        op_t         op;
        logic [7:0]  operand;
        logic        acc_mode;
        logic [15:0] mem_address;
        logic [15:0] pc;
        logic [7:0]  branch_offset;
    } item_t;

    typedef struct packed {
        logic        write_valid;
        logic [15:0] write_address;
        logic [7:0]  write_data;
        logic        branch_taken;
        logic [15:0] next_pc;
        logic        page_crossed;
        logic [7:0]  a_value;
        logic [7:0]  x_value;
        logic [7:0]  y_value;
        logic [7:0]  status_value;
        logic [7:0]  stack_value;
    } result_t;

endpackage

// ===== rtl/c8eu_front.sv =====
// ----------------------------------------------------------------------------
// c8eu_front
// Input stage: takes a word, maps undefined codes to NOP, holds a
// two-entry queue toward the back end.
// ----------------------------------------------------------------------------
module c8eu_front
    import c8eu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [5:0]  op,
    input  logic [7:0]  operand,
    input  logic        accumulator_mode,
    input  logic [15:0] mem_address,
    input  logic [15:0] pc,
    input  logic [7:0]  branch_offset,
    output logic        item_valid,
    output item_t       item,
    input  logic        item_take
);

    item_t      q_reg [2];
    logic       rd_reg, rd_next;
    logic       wr_reg, wr_next;
    logic [1:0] cnt_reg, cnt_next;
    item_t      in_item;
    logic       do_push;

    always_comb
    begin
        in_item.op            = (op > 6'd46) ? OP_NOP : op_t'(op);
        in_item.operand       = operand;
        in_item.acc_mode      = accumulator_mode;
        in_item.mem_address   = mem_address;
        in_item.pc            = pc;
        in_item.branch_offset = branch_offset;
    end

    assign full       = (cnt_reg == 2'd2);
    assign do_push    = push && !full;
    assign item_valid = (cnt_reg != 2'd0);
    assign item       = q_reg[rd_reg];

    always_comb
    begin
        rd_next  = rd_reg ^ (item_take && item_valid);
        wr_next  = wr_reg ^ do_push;
        cnt_next = cnt_reg + {1'b0, do_push} - {1'b0, item_take && item_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_reg] <= in_item;
        end
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3) else $error("queue count overflow");
    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full && !item_take) |=> cnt_reg == $past(cnt_reg) + 2'd1)
        else $error("count missed a push");
    a_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0 || cnt_reg == 2'd2) |-> rd_reg == wr_reg)
        else $error("pointer mismatch");

endmodule

// ===== rtl/c8eu_back.sv =====
// ----------------------------------------------------------------------------
// c8eu_back
// Execute stage: register file, ALU pass, branch unit and a two-entry
// result queue.
// ----------------------------------------------------------------------------
module c8eu_back
    import c8eu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  item_t       item,
    output logic        item_take,
    output logic        res_empty,
    output result_t     res,
    input  logic        res_pop
);

    logic [7:0] a_reg, a_next, x_reg, x_next, y_reg, y_next;
    logic [7:0] s_reg, s_next, p_reg, p_next;
    result_t    rq_reg [2];
    logic       rrd_reg, rwr_reg;
    logic [1:0] rcnt_reg;
    result_t    r;
    logic [8:0] sum;
    logic [7:0] m, src, sh, cmp_reg, diff;
    logic       take, do_pop, cin, taken, want_set, flag_on;
    logic [15:0] tgt;

    assign do_pop    = res_pop && !res_empty;
    assign res_empty = (rcnt_reg == 2'd0);
    assign item_take = (rcnt_reg != 2'd2);
    assign take      = item_valid && item_take;
    assign res       = rq_reg[rrd_reg];

    always_comb
    begin
        a_next = a_reg;
        x_next = x_reg;
        y_next = y_reg;
        s_next = s_reg;
        p_next = p_reg;
        cin    = p_reg[FLAG_C];
        m      = (item.op == OP_SBC) ? ~item.operand : item.operand;
        sum    = {1'b0, a_reg} + {1'b0, m} + {8'd0, cin};
        src    = item.acc_mode ? a_reg : item.operand;
        sh     = 8'd0;
        cmp_reg = (item.op == OP_CPX) ? x_reg : ((item.op == OP_CPY) ? y_reg : a_reg);
        diff   = cmp_reg - item.operand;
        r      = '0;
        r.next_pc = item.pc;
        unique case (item.op)
            OP_ADC, OP_SBC:
            begin
                a_next = sum[7:0];
                p_next[FLAG_C] = sum[8];
                p_next[FLAG_V] = (a_reg[7] ^ sum[7]) & (m[7] ^ sum[7]);
            end
            OP_AND: a_next = a_reg & item.operand;
            OP_ORA: a_next = a_reg | item.operand;
            OP_EOR: a_next = a_reg ^ item.operand;
            OP_ASL, OP_LSR, OP_ROL, OP_ROR:
            begin
                case (item.op)
                    OP_ASL: sh = {src[6:0], 1'b0};
                    OP_LSR: sh = {1'b0, src[7:1]};
                    OP_ROL: sh = {src[6:0], cin};
                    default: sh = {cin, src[7:1]};
                endcase
                p_next[FLAG_C] = (item.op == OP_ASL || item.op == OP_ROL) ? src[7] : src[0];
                p_next[FLAG_Z] = (sh == 8'd0);
                p_next[FLAG_N] = sh[7];
                if (item.acc_mode)
                begin
                    a_next = sh;
                end
                else
                begin
                    r.write_valid = 1'b1;
                    r.write_data  = sh;
                end
            end
            OP_BIT:
            begin
                p_next[FLAG_Z] = ((a_reg & item.operand) == 8'd0);
                p_next[FLAG_V] = item.operand[6];
                p_next[FLAG_N] = item.operand[7];
            end
            OP_CMP, OP_CPX, OP_CPY:
            begin
                p_next[FLAG_C] = (cmp_reg >= item.operand);
                p_next[FLAG_Z] = (cmp_reg == item.operand);
                p_next[FLAG_N] = diff[7];
            end
            OP_INC, OP_DEC:
            begin
                r.write_valid = 1'b1;
                r.write_data  = (item.op == OP_INC) ? item.operand + 8'd1
                                                    : item.operand - 8'd1;
                p_next[FLAG_Z] = (r.write_data == 8'd0);
                p_next[FLAG_N] = r.write_data[7];
            end
            OP_INX: x_next = x_reg + 8'd1;
            OP_INY: y_next = y_reg + 8'd1;
            OP_DEX: x_next = x_reg - 8'd1;
            OP_DEY: y_next = y_reg - 8'd1;
            OP_LDA: a_next = item.operand;
            OP_LDX: x_next = item.operand;
            OP_LDY: y_next = item.operand;
            OP_STA: begin r.write_valid = 1'b1; r.write_data = a_reg; end
            OP_STX: begin r.write_valid = 1'b1; r.write_data = x_reg; end
            OP_STY: begin r.write_valid = 1'b1; r.write_data = y_reg; end
            OP_TAX: x_next = a_reg;
            OP_TAY: y_next = a_reg;
            OP_TXA: a_next = x_reg;
            OP_TYA: a_next = y_reg;
            OP_TSX: x_next = s_reg;
            OP_TXS: s_next = x_reg;
            OP_CLC: p_next[FLAG_C] = 1'b0;
            OP_SEC: p_next[FLAG_C] = 1'b1;
            OP_CLI: p_next[FLAG_I] = 1'b0;
            OP_SEI: p_next[FLAG_I] = 1'b1;
            OP_CLD: p_next[FLAG_D] = 1'b0;
            OP_SED: p_next[FLAG_D] = 1'b1;
            OP_CLV: p_next[FLAG_V] = 1'b0;
            default: ;
        endcase
        // N/Z from register results
        case (item.op)
            OP_AND, OP_ORA, OP_EOR, OP_LDA, OP_TXA, OP_TYA:
            begin
                p_next[FLAG_Z] = (a_next == 8'd0);
                p_next[FLAG_N] = a_next[7];
            end
            OP_ADC, OP_SBC:
            begin
                p_next[FLAG_Z] = (a_next == 8'd0);
                p_next[FLAG_N] = a_next[7];
            end
            OP_INX, OP_DEX, OP_LDX, OP_TAX, OP_TSX:
            begin
                p_next[FLAG_Z] = (x_next == 8'd0);
                p_next[FLAG_N] = x_next[7];
            end
            OP_INY, OP_DEY, OP_LDY, OP_TAY:
            begin
                p_next[FLAG_Z] = (y_next == 8'd0);
                p_next[FLAG_N] = y_next[7];
            end
            default: ;
        endcase
        case (item.op)
            OP_BCC, OP_BCS: flag_on = p_reg[FLAG_C];
            OP_BEQ, OP_BNE: flag_on = p_reg[FLAG_Z];
            OP_BMI, OP_BPL: flag_on = p_reg[FLAG_N];
            default:        flag_on = p_reg[FLAG_V];
        endcase
        want_set = (item.op == OP_BCS) || (item.op == OP_BEQ) ||
                   (item.op == OP_BMI) || (item.op == OP_BVS);
        taken = (item.op >= OP_BCC) && (item.op <= OP_BVS) && (flag_on == want_set);
        tgt   = item.pc + {{8{item.branch_offset[7]}}, item.branch_offset};
        if (taken)
        begin
            r.branch_taken = 1'b1;
            r.next_pc      = tgt;
            r.page_crossed = (tgt[15:8] != item.pc[15:8]);
        end
        p_next[FLAG_U] = 1'b1;
        if (r.write_valid)
        begin
            r.write_address = item.mem_address;
        end
        r.a_value      = a_next;
        r.x_value      = x_next;
        r.y_value      = y_next;
        r.status_value = p_next;
        r.stack_value  = s_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg    <= 8'd0;
            x_reg    <= 8'd0;
            y_reg    <= 8'd0;
            s_reg    <= SP_RESET;
            p_reg    <= 8'd0;
            rrd_reg  <= 1'b0;
            rwr_reg  <= 1'b0;
            rcnt_reg <= 2'd0;
        end
        else
        begin
            if (take)
            begin
                a_reg <= a_next;
                x_reg <= x_next;
                y_reg <= y_next;
                s_reg <= s_next;
                p_reg <= p_next;
            end
            rrd_reg  <= rrd_reg ^ do_pop;
            rwr_reg  <= rwr_reg ^ take;
            rcnt_reg <= rcnt_reg + {1'b0, take} - {1'b0, do_pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            rq_reg[rwr_reg] <= r;
        end
    end

    a_rcnt: assert property (@(posedge clk) disable iff (!rst_n)
        rcnt_reg != 2'd3) else $error("result queue overflow");
    a_u_set: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> p_reg[FLAG_U]) else $error("U flag not set");
    a_regs_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !take |=> $stable(a_reg) && $stable(p_reg)) else $error("state moved");
    a_npc: assert property (@(posedge clk) disable iff (!rst_n)
        (take && !taken) |-> r.next_pc == item.pc) else $error("bad next pc");

endmodule

// ===== rtl/cpu8_execute_unit.sv =====
// Path: a pushed word is registered in the front queue, passes the
// combinational ALU and is registered in the result queue, ready to pop.
// Throughput: one word per cycle unless a queue is full; ALU is combinational.
// Two-entry queues at input and output decouple both sides.
// Reset: A, X, Y and status clear to zero, stack pointer to 0xFD.
// ----------------------------------------------------------------------------
// cpu8_execute_unit
// Execute stage of an 8-bit core: front queue plus ALU back end.
// ----------------------------------------------------------------------------
module cpu8_execute_unit
    import c8eu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [5:0]  op,
    input  logic [7:0]  operand,
    input  logic        accumulator_mode,
    input  logic [15:0] mem_address,
    input  logic [15:0] pc,
    input  logic signed [7:0] branch_offset,
    output logic        empty,
    input  logic        pop,
    output logic        write_valid,
    output logic [15:0] write_address,
    output logic [7:0]  write_data,
    output logic        branch_taken,
    output logic [15:0] next_pc,
    output logic        page_crossed,
    output logic [7:0]  a_value,
    output logic [7:0]  x_value,
    output logic [7:0]  y_value,
    output logic [7:0]  status_value,
    output logic [7:0]  stack_value
);

    item_t   item;
    logic    item_valid, item_take;
    result_t res;

    c8eu_front u_front (
        .clk, .rst_n, .push, .full, .op, .operand, .accumulator_mode,
        .mem_address, .pc, .branch_offset(branch_offset[7:0]),
        .item_valid, .item, .item_take
    );

    c8eu_back u_back (
        .clk, .rst_n, .item_valid, .item, .item_take,
        .res_empty(empty), .res, .res_pop(pop)
    );

    assign write_valid   = res.write_valid;
    assign write_address = res.write_address;
    assign write_data    = res.write_data;
    assign branch_taken  = res.branch_taken;
    assign next_pc       = res.next_pc;
    assign page_crossed  = res.page_crossed;
    assign a_value       = res.a_value;
    assign x_value       = res.x_value;
    assign y_value       = res.y_value;
    assign status_value  = res.status_value;
    assign stack_value   = res.stack_value;

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 8-bit execute unit: drives decoded operations
// through the push/full queue, predicts every result word from a register
// model of the core, and compares each popped word field by field.
// ----------------------------------------------------------------------------
module tb;
    import c8eu_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 5000;

    class exec_scoreboard;
        logic [7:0] acc, xr, yr, sp, st;
        result_t    pending[$];
        int         errors;
        int         checked;

        function new();
            acc = 8'h00; xr = 8'h00; yr = 8'h00; sp = SP_RESET; st = 8'h00;
            errors = 0; checked = 0;
        endfunction

        function void set_nz(logic [7:0] v);
            st[FLAG_Z] = (v == 8'h00);
            st[FLAG_N] = v[7];
        endfunction

        function void add_carry(logic [7:0] m);
            logic [8:0] sum;
            sum = {1'b0, acc} + {1'b0, m} + {8'b0, st[FLAG_C]};
            st[FLAG_C] = sum[8];
            st[FLAG_V] = (acc[7] ^ sum[7]) & (m[7] ^ sum[7]);
            acc = sum[7:0];
            set_nz(acc);
        endfunction

        function void compare(logic [7:0] r, logic [7:0] m);
            logic [7:0] d;
            d = r - m;
            st[FLAG_C] = (r >= m);
            st[FLAG_Z] = (r == m);
            st[FLAG_N] = d[7];
        endfunction

        function void note_word(item_t it);
            result_t    res;
            logic [7:0] src, r;
            logic       cin, flag, want;
            logic [15:0] target;
            res = '0;
            res.next_pc = it.pc;
            cin = st[FLAG_C];
            case (it.op)
                OP_ADC: add_carry(it.operand);
                OP_SBC: add_carry(~it.operand);
                OP_AND: begin acc = acc & it.operand; set_nz(acc); end
                OP_ORA: begin acc = acc | it.operand; set_nz(acc); end
                OP_EOR: begin acc = acc ^ it.operand; set_nz(acc); end
                OP_ASL, OP_LSR, OP_ROL, OP_ROR:
                begin
                    src = it.acc_mode ? acc : it.operand;
                    if (it.op == OP_ASL || it.op == OP_ROL)
                    begin
                        r = {src[6:0], (it.op == OP_ROL) ? cin : 1'b0};
                        st[FLAG_C] = src[7];
                    end
                    else
                    begin
                        r = {(it.op == OP_ROR) ? cin : 1'b0, src[7:1]};
                        st[FLAG_C] = src[0];
                    end
                    set_nz(r);
                    if (it.acc_mode)
                        acc = r;
                    else
                    begin
                        res.write_valid = 1'b1;
                        res.write_data = r;
                    end
                end
                OP_BIT:
                begin
                    st[FLAG_Z] = ((acc & it.operand) == 8'h00);
                    st[FLAG_V] = it.operand[6];
                    st[FLAG_N] = it.operand[7];
                end
                OP_CMP: compare(acc, it.operand);
                OP_CPX: compare(xr, it.operand);
                OP_CPY: compare(yr, it.operand);
                OP_INC:
                begin
                    res.write_valid = 1'b1; res.write_data = it.operand + 8'd1;
                    set_nz(res.write_data);
                end
                OP_DEC:
                begin
                    res.write_valid = 1'b1; res.write_data = it.operand - 8'd1;
                    set_nz(res.write_data);
                end
                OP_INX: begin xr = xr + 8'd1; set_nz(xr); end
                OP_INY: begin yr = yr + 8'd1; set_nz(yr); end
                OP_DEX: begin xr = xr - 8'd1; set_nz(xr); end
                OP_DEY: begin yr = yr - 8'd1; set_nz(yr); end
                OP_LDA: begin acc = it.operand; set_nz(acc); end
                OP_LDX: begin xr = it.operand; set_nz(xr); end
                OP_LDY: begin yr = it.operand; set_nz(yr); end
                OP_STA: begin res.write_valid = 1'b1; res.write_data = acc; end
                OP_STX: begin res.write_valid = 1'b1; res.write_data = xr; end
                OP_STY: begin res.write_valid = 1'b1; res.write_data = yr; end
                OP_TAX: begin xr = acc; set_nz(xr); end
                OP_TAY: begin yr = acc; set_nz(yr); end
                OP_TXA: begin acc = xr; set_nz(acc); end
                OP_TYA: begin acc = yr; set_nz(acc); end
                OP_TSX: begin xr = sp; set_nz(xr); end
                OP_TXS: sp = xr;
                OP_CLC: st[FLAG_C] = 1'b0;
                OP_SEC: st[FLAG_C] = 1'b1;
                OP_CLI: st[FLAG_I] = 1'b0;
                OP_SEI: st[FLAG_I] = 1'b1;
                OP_CLD: st[FLAG_D] = 1'b0;
                OP_SED: st[FLAG_D] = 1'b1;
                OP_CLV: st[FLAG_V] = 1'b0;
                OP_BCC, OP_BCS, OP_BEQ, OP_BNE, OP_BMI, OP_BPL, OP_BVC, OP_BVS:
                begin
                    if (it.op == OP_BCC || it.op == OP_BCS) flag = st[FLAG_C];
                    else if (it.op == OP_BEQ || it.op == OP_BNE) flag = st[FLAG_Z];
                    else if (it.op == OP_BMI || it.op == OP_BPL) flag = st[FLAG_N];
                    else flag = st[FLAG_V];
                    want = (it.op == OP_BCS || it.op == OP_BEQ || it.op == OP_BMI
                            || it.op == OP_BVS);
                    if (flag == want)
                    begin
                        target = it.pc + {{8{it.branch_offset[7]}}, it.branch_offset};
                        res.branch_taken = 1'b1;
                        res.next_pc = target;
                        res.page_crossed = (target[15:8] != it.pc[15:8]);
                    end
                end
                default: ;
            endcase
            st[FLAG_U] = 1'b1;
            if (res.write_valid)
                res.write_address = it.mem_address;
            res.a_value = acc; res.x_value = xr; res.y_value = yr;
            res.status_value = st; res.stack_value = sp;
            pending.push_back(res);
        endfunction

        task check_word(result_t got);
            result_t want;
            if (pending.size() == 0)
            begin
                report("unexpected word", 16'h0000, 16'h0000);
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.write_valid !== want.write_valid)
                report("write_valid", 16'(got.write_valid), 16'(want.write_valid));
            if (got.write_address !== want.write_address)
                report("write_address", got.write_address, want.write_address);
            if (got.write_data !== want.write_data)
                report("write_data", 16'(got.write_data), 16'(want.write_data));
            if (got.branch_taken !== want.branch_taken)
                report("branch_taken", 16'(got.branch_taken), 16'(want.branch_taken));
            if (got.next_pc !== want.next_pc)
                report("next_pc", got.next_pc, want.next_pc);
            if (got.page_crossed !== want.page_crossed)
                report("page_crossed", 16'(got.page_crossed), 16'(want.page_crossed));
            if (got.a_value !== want.a_value)
                report("a_value", 16'(got.a_value), 16'(want.a_value));
            if (got.x_value !== want.x_value)
                report("x_value", 16'(got.x_value), 16'(want.x_value));
            if (got.y_value !== want.y_value)
                report("y_value", 16'(got.y_value), 16'(want.y_value));
            if (got.status_value !== want.status_value)
                report("status_value", 16'(got.status_value), 16'(want.status_value));
            if (got.stack_value !== want.stack_value)
                report("stack_value", 16'(got.stack_value), 16'(want.stack_value));
        endtask

        task report(string what, logic [15:0] got, logic [15:0] want);
            errors++;
            if (errors <= 40)
                $display("mismatch word %0d %s: got %h want %h", checked, what, got, want);
        endtask
    endclass

    logic        clk, rst_n, push, pop;
    logic        full, empty;
    logic [5:0]  op;
    logic [7:0]  operand;
    logic        accumulator_mode;
    logic [15:0] mem_address, pc;
    logic signed [7:0] branch_offset;
    logic        write_valid, branch_taken, page_crossed;
    logic [15:0] write_address, next_pc;
    logic [7:0]  write_data, a_value, x_value, y_value, status_value, stack_value;

    exec_scoreboard sb;
    bit  quiet_phase;
    bit  hold_off;
    bit  stim_done;
    int  sent;
    int  idle_cycles;

    cpu8_execute_unit u_top (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic send_word(logic [5:0] o, logic [7:0] m, logic am,
                             logic [15:0] addr, logic [15:0] p, logic [7:0] off);
        int gap;
        if (!quiet_phase && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 5);
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        op <= o; operand <= m; accumulator_mode <= am;
        mem_address <= addr; pc <= p; branch_offset <= off;
        do @(posedge clk); while (full);
        sb.note_word('{op_t'(o), m, am, addr, p, off});
        sent++;
    endtask

    task automatic send_random();
        int sel;
        logic [5:0] o;
        sel = $urandom_range(0, 99);
        if (sel < 3)
            o = 6'($urandom_range(47, 63));
        else if (sel < 20)
            o = 6'($urandom_range(OP_BCC, OP_BVS));
        else if (sel < 30)
            o = 6'($urandom_range(OP_CLC, OP_CLV));
        else
            o = 6'($urandom_range(0, 46));
        send_word(o, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                  8'($urandom_range(0, 255)));
    endtask

    task automatic directed_words();
        send_word(OP_NOP, 8'h00, 1'b0, 16'h0000, 16'h0000, 8'h00);
        send_word(OP_LDA, 8'h7F, 1'b0, 16'h0000, 16'h0000, 8'h00);
        send_word(OP_ADC, 8'h01, 1'b0, 16'h0000, 16'h0000, 8'h00);
        send_word(OP_SEC, 8'h00, 1'b0, 16'h0000, 16'h0000, 8'h00);
        send_word(OP_SBC, 8'hFF, 1'b0, 16'h0000, 16'h0000, 8'h00);
        send_word(OP_ADC, 8'hFF, 1'b0, 16'h0000, 16'h0000, 8'h00);
        send_word(OP_BIT, 8'hC0, 1'b0, 16'h0000, 16'h0000, 8'h00);
        send_word(OP_BVS, 8'h00, 1'b0, 16'h0000, 16'h00FF, 8'h7F);
        send_word(OP_BMI, 8'h00, 1'b0, 16'h0000, 16'h0100, 8'h80);
        send_word(OP_ROR, 8'h01, 1'b1, 16'hFFFF, 16'hFFFF, 8'hFF);
        send_word(OP_ROL, 8'h80, 1'b0, 16'hFFFF, 16'hFFFF, 8'hFF);
        send_word(OP_ASL, 8'hFF, 1'b0, 16'hFFFF, 16'h0000, 8'h00);
        send_word(OP_LSR, 8'h01, 1'b1, 16'h1234, 16'h0000, 8'h00);
        send_word(OP_DEX, 8'h00, 1'b0, 16'h0000, 16'h0000, 8'h00);
        send_word(OP_TXS, 8'h00, 1'b0, 16'h0000, 16'h0000, 8'h00);
        send_word(OP_TSX, 8'h00, 1'b0, 16'h0000, 16'h0000, 8'h00);
        send_word(OP_INC, 8'hFF, 1'b0, 16'hFFFF, 16'h0000, 8'h00);
        send_word(OP_DEC, 8'h00, 1'b0, 16'h8000, 16'h0000, 8'h00);
        send_word(OP_CPX, 8'hFF, 1'b0, 16'h0000, 16'h0000, 8'h00);
        send_word(OP_STX, 8'h00, 1'b0, 16'hABCD, 16'h0000, 8'h00);
        send_word(OP_BEQ, 8'h00, 1'b0, 16'h0000, 16'hFFFE, 8'h05);
        send_word(6'd63, 8'hFF, 1'b1, 16'hFFFF, 16'hFFFF, 8'hFF);
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0; push = 1'b0; pop = 1'b0;
        op = '0; operand = '0; accumulator_mode = 1'b0;
        mem_address = '0; pc = '0; branch_offset = '0;
        quiet_phase = 0; hold_off = 0; stim_done = 0; sent = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed_words();
        for (int k = 0; k < 1200; k++)
        begin
            if (k == 1000)
                quiet_phase = 1;
            send_random();
        end
        push <= 1'b0;
        stim_done = 1;
    end

    initial
    begin
        @(posedge rst_n);
        repeat (300) @(posedge clk);
        hold_off = 1;
        repeat (60) @(posedge clk);
        hold_off = 0;
    end

    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            if (hold_off)
            begin
                pop <= 1'b0;
                @(posedge clk);
            end
            else if (!quiet_phase && $urandom_range(0, 3) == 0)
            begin
                gap = $urandom_range(1, 5);
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            else
            begin
                pop <= 1'b1;
                @(posedge clk);
                if (!empty)
                    sb.check_word('{write_valid, write_address, write_data,
                                    branch_taken, next_pc, page_crossed, a_value,
                                    x_value, y_value, status_value, stack_value});
            end
        end
    end

    initial
    begin
        @(posedge rst_n);
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (stim_done && sb.pending.size() == 0)
            begin
                repeat (10) @(posedge clk);
                $display("covered %0d words incl. undefined codes, branches and a long stall,",
                         sent);
                $display("%0d result words checked", sb.checked);
                if (sb.errors == 0 && sb.pending.size() == 0)
                    $display("tb: PASS");
                else
                    $display("tb: FAIL");
                $finish;
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog expired, %0d words pending", sb.pending.size());
                $display("tb: FAIL");
                $finish;
            end
        end
    end
endmodule
